@@ rtl/core/lru_sector_cache_tags_core_assert.svh @@
// -----------------------------------------------------------------------------
// LRU sector cache tags: assertion macros
// Concurrent assertion forms used by the cache tag datapath module.
// -----------------------------------------------------------------------------
`ifndef LRU_SECTOR_CACHE_TAGS_CORE_ASSERT_SVH
`define LRU_SECTOR_CACHE_TAGS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lsc_pkg.sv @@
// -----------------------------------------------------------------------------
// LRU sector cache tags: package
// Widths, codes, state machine type and controller/datapath bundles.
// -----------------------------------------------------------------------------
package lsc_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int OP_W          = 2;
  localparam int SECTOR_W      = 8;
  localparam int KIND_W        = 2;
  localparam int SLOT_W        = 4;
  localparam int TICK_W        = 32;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // Result kind codes.
  localparam logic [KIND_W-1:0] KIND_GRANT      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH_DONE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_EVICT_COMMIT,
    ST_EVICT_GRANT,
    ST_FLUSH
  } state_t;

  // Which result the datapath builds when the output register is loaded.
  typedef enum logic [2:0] {
    SEL_HIT_GRANT,
    SEL_FREE_GRANT,
    SEL_LOOKUP,
    SEL_EVICT_COMMIT,
    SEL_EVICT_GRANT,
    SEL_FLUSH_COMMIT,
    SEL_FLUSH_DONE
  } sel_t;

  typedef struct packed {
    logic req_load;
    logic scan_init;
    logic scan_step;
    logic out_load;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            free_any;
    logic            any_valid;
    logic            scan_done;
    logic            out_free;
    logic            flush_last;
  } sts_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] committed_sector;
    logic                hit;
    logic                fill;
    logic                last;
  } res_t;

endpackage

@@ rtl/core/lsc_channel_if.sv @@
// -----------------------------------------------------------------------------
// LRU sector cache tags: channel interfaces
// Valid/ready request and result channels with source and sink modports.
// -----------------------------------------------------------------------------
interface lsc_req_if;
  logic                         valid;
  logic                         ready;
  logic [lsc_pkg::OP_W-1:0]     op;
  logic [lsc_pkg::SECTOR_W-1:0] sector_index;

  modport source (output valid, output op, output sector_index, input ready);
  modport sink (input valid, input op, input sector_index, output ready);
endinterface

interface lsc_res_if;
  logic                         valid;
  logic                         ready;
  logic [lsc_pkg::KIND_W-1:0]   kind;
  logic [lsc_pkg::SLOT_W-1:0]   slot;
  logic [lsc_pkg::SECTOR_W-1:0] committed_sector;
  logic                         hit;
  logic                         fill;
  logic                         last;

  modport source (output valid, output kind, output slot, output committed_sector,
                  output hit, output fill, output last, input ready);
  modport sink (input valid, input kind, input slot, input committed_sector,
                input hit, input fill, input last, output ready);
endinterface

@@ rtl/core/lsc_ctrl.sv @@
// -----------------------------------------------------------------------------
// LRU sector cache tags: controller
// Sequences one request at a time through decide, victim scan and result
// emission, commanding the datapath.
// -----------------------------------------------------------------------------
module lsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lsc_pkg::sts_t sts,
  output lsc_pkg::cmd_t cmd
);

  lsc_pkg::state_t state;
  lsc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lsc_pkg::ST_IDLE: begin
        if (in_valid) state_next = lsc_pkg::ST_DECIDE;
      end
      lsc_pkg::ST_DECIDE: begin
        case (sts.op)
          lsc_pkg::OP_GET: begin
            if (sts.hit || sts.free_any) begin
              if (sts.out_free) state_next = lsc_pkg::ST_IDLE;
            end else begin
              state_next = lsc_pkg::ST_SCAN;
            end
          end
          lsc_pkg::OP_LOOKUP: begin
            if (sts.out_free) state_next = lsc_pkg::ST_IDLE;
          end
          lsc_pkg::OP_FLUSH: begin
            if (sts.any_valid) begin
              state_next = lsc_pkg::ST_FLUSH;
            end else if (sts.out_free) begin
              state_next = lsc_pkg::ST_IDLE;
            end
          end
          default: state_next = lsc_pkg::ST_IDLE;
        endcase
      end
      lsc_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = lsc_pkg::ST_EVICT_COMMIT;
      end
      lsc_pkg::ST_EVICT_COMMIT: begin
        if (sts.out_free) state_next = lsc_pkg::ST_EVICT_GRANT;
      end
      lsc_pkg::ST_EVICT_GRANT: begin
        if (sts.out_free) state_next = lsc_pkg::ST_IDLE;
      end
      lsc_pkg::ST_FLUSH: begin
        if (sts.out_free && sts.flush_last) state_next = lsc_pkg::ST_IDLE;
      end
      default: state_next = lsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.req_load  = 1'b0;
    cmd.scan_init = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.sel       = lsc_pkg::SEL_LOOKUP;
    case (state)
      lsc_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.req_load = in_valid;
      end
      lsc_pkg::ST_DECIDE: begin
        case (sts.op)
          lsc_pkg::OP_GET: begin
            if (sts.hit) begin
              cmd.out_load = sts.out_free;
              cmd.sel      = lsc_pkg::SEL_HIT_GRANT;
            end else if (sts.free_any) begin
              cmd.out_load = sts.out_free;
              cmd.sel      = lsc_pkg::SEL_FREE_GRANT;
            end else begin
              cmd.scan_init = 1'b1;
            end
          end
          lsc_pkg::OP_LOOKUP: begin
            cmd.out_load = sts.out_free;
            cmd.sel      = lsc_pkg::SEL_LOOKUP;
          end
          lsc_pkg::OP_FLUSH: begin
            if (!sts.any_valid) begin
              cmd.out_load = sts.out_free;
              cmd.sel      = lsc_pkg::SEL_FLUSH_DONE;
            end
          end
          default: cmd.out_load = 1'b0;
        endcase
      end
      lsc_pkg::ST_SCAN: begin
        cmd.scan_step = !sts.scan_done;
      end
      lsc_pkg::ST_EVICT_COMMIT: begin
        cmd.out_load = sts.out_free;
        cmd.sel      = lsc_pkg::SEL_EVICT_COMMIT;
      end
      lsc_pkg::ST_EVICT_GRANT: begin
        cmd.out_load = sts.out_free;
        cmd.sel      = lsc_pkg::SEL_EVICT_GRANT;
      end
      lsc_pkg::ST_FLUSH: begin
        cmd.out_load = sts.out_free;
        cmd.sel      = lsc_pkg::SEL_FLUSH_COMMIT;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/lsc_dp.sv @@
// -----------------------------------------------------------------------------
// LRU sector cache tags: datapath
// Slot tags, use ticks, victim scan unit, flush pick logic and the result
// output register.
// -----------------------------------------------------------------------------
`include "lru_sector_cache_tags_core_assert.svh"

module lsc_dp #(
  parameter int NUM_SLOTS = lsc_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lsc_pkg::cmd_t                cmd,
  output lsc_pkg::sts_t                sts,
  input  logic [lsc_pkg::OP_W-1:0]     in_op,
  input  logic [lsc_pkg::SECTOR_W-1:0] in_sec_idx,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lsc_pkg::res_t                out_data
);

  localparam int IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW     = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W = lsc_pkg::SLOT_W;
  localparam int TICK_W = lsc_pkg::TICK_W;
  localparam int SEC_W  = lsc_pkg::SECTOR_W;

  logic [NUM_SLOTS-1:0] slot_valid;
  logic [SEC_W-1:0]     slot_sector   [NUM_SLOTS];
  logic [TICK_W-1:0]    slot_last_use [NUM_SLOTS];
  logic [TICK_W-1:0]    use_tick;

  logic [lsc_pkg::OP_W-1:0] req_op;
  logic [SEC_W-1:0]         req_sector;

  logic [CW-1:0]     scan_idx;
  logic [IW-1:0]     best_idx;
  logic [TICK_W-1:0] best_tick;

  logic              match_any;
  logic [IW-1:0]     match_idx;
  logic              free_any;
  logic [IW-1:0]     free_idx;
  logic              fl_any_data;
  logic [IW-1:0]     fl_data_idx;
  logic [IW-1:0]     fl_hdr_idx;
  logic [IW-1:0]     fl_idx;
  logic              fl_last;
  logic [NUM_SLOTS-1:0] fl_remaining;
  logic [IW-1:0]     cm_idx;
  logic [IW-1:0]     wr_idx;
  logic              install;
  logic              stamp;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] scan_tick;
  logic              scan_done;
  lsc_pkg::res_t     res_new;

  // Priority encoders: lowest index wins, so loops run from the top down.
  always_comb begin
    match_any   = 1'b0;
    match_idx   = '0;
    free_any    = 1'b0;
    free_idx    = '0;
    fl_any_data = 1'b0;
    fl_data_idx = '0;
    fl_hdr_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_sector[i] == req_sector) begin
        match_any = 1'b1;
        match_idx = IW'(i);
      end
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
      if (slot_valid[i] && slot_sector[i] != '0) begin
        fl_any_data = 1'b1;
        fl_data_idx = IW'(i);
      end
      if (slot_valid[i] && slot_sector[i] == '0) begin
        fl_hdr_idx = IW'(i);
      end
    end
  end

  // The header sector is held back until every data sector is committed.
  assign fl_idx = fl_any_data ? fl_data_idx : fl_hdr_idx;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      fl_remaining[i] = slot_valid[i] && (IW'(i) != fl_idx);
    end
  end
  assign fl_last = (fl_remaining == '0);

  assign scan_done = (scan_idx == CW'(NUM_SLOTS));
  assign scan_tick = slot_last_use[scan_idx[IW-1:0]];
  assign tick_inc  = use_tick + TICK_W'(1);

  assign cm_idx  = (cmd.sel == lsc_pkg::SEL_EVICT_COMMIT) ? best_idx : fl_idx;
  assign install = cmd.out_load && (cmd.sel == lsc_pkg::SEL_FREE_GRANT ||
                                    cmd.sel == lsc_pkg::SEL_EVICT_GRANT);
  assign stamp   = install || (cmd.out_load && cmd.sel == lsc_pkg::SEL_HIT_GRANT);

  always_comb begin
    case (cmd.sel)
      lsc_pkg::SEL_HIT_GRANT:  wr_idx = match_idx;
      lsc_pkg::SEL_FREE_GRANT: wr_idx = free_idx;
      default:                 wr_idx = best_idx;
    endcase
  end

  always_comb begin
    res_new = '0;
    case (cmd.sel)
      lsc_pkg::SEL_HIT_GRANT: begin
        res_new.kind = lsc_pkg::KIND_GRANT;
        res_new.slot = SLOT_W'(match_idx);
        res_new.hit  = 1'b1;
        res_new.last = 1'b1;
      end
      lsc_pkg::SEL_FREE_GRANT: begin
        res_new.kind = lsc_pkg::KIND_GRANT;
        res_new.slot = SLOT_W'(free_idx);
        res_new.fill = 1'b1;
        res_new.last = 1'b1;
      end
      lsc_pkg::SEL_LOOKUP: begin
        res_new.kind = lsc_pkg::KIND_GRANT;
        res_new.slot = match_any ? SLOT_W'(match_idx) : '0;
        res_new.hit  = match_any;
        res_new.last = 1'b1;
      end
      lsc_pkg::SEL_EVICT_COMMIT: begin
        res_new.kind             = lsc_pkg::KIND_COMMIT;
        res_new.slot             = SLOT_W'(cm_idx);
        res_new.committed_sector = slot_sector[cm_idx];
      end
      lsc_pkg::SEL_EVICT_GRANT: begin
        res_new.kind = lsc_pkg::KIND_GRANT;
        res_new.slot = SLOT_W'(best_idx);
        res_new.fill = 1'b1;
        res_new.last = 1'b1;
      end
      lsc_pkg::SEL_FLUSH_COMMIT: begin
        res_new.kind             = lsc_pkg::KIND_COMMIT;
        res_new.slot             = SLOT_W'(cm_idx);
        res_new.committed_sector = slot_sector[cm_idx];
        res_new.last             = fl_last;
      end
      lsc_pkg::SEL_FLUSH_DONE: begin
        res_new.kind = lsc_pkg::KIND_FLUSH_DONE;
        res_new.last = 1'b1;
      end
      default: res_new = '0;
    endcase
  end

  // Control state: valid bits, tick counter, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      use_tick   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (install) slot_valid[wr_idx] <= 1'b1;
      if (cmd.out_load && cmd.sel == lsc_pkg::SEL_FLUSH_COMMIT) begin
        slot_valid[fl_idx] <= 1'b0;
      end
      if (stamp) use_tick <= tick_inc;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: tags, ticks, request, scan registers, result.
  always_ff @(posedge clk) begin
    if (install) slot_sector[wr_idx] <= req_sector;
    if (stamp) slot_last_use[wr_idx] <= tick_inc;
    if (cmd.req_load) begin
      req_op     <= in_op;
      req_sector <= in_sec_idx;
    end
    if (cmd.scan_init) begin
      best_idx  <= '0;
      best_tick <= slot_last_use[0];
      scan_idx  <= CW'(1);
    end else if (cmd.scan_step) begin
      if (scan_tick < best_tick) begin
        best_idx  <= scan_idx[IW-1:0];
        best_tick <= scan_tick;
      end
      scan_idx <= scan_idx + CW'(1);
    end
    if (cmd.out_load) out_data <= res_new;
  end

  assign sts.op         = req_op;
  assign sts.hit        = match_any;
  assign sts.free_any   = free_any;
  assign sts.any_valid  = (slot_valid != '0);
  assign sts.scan_done  = scan_done;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.flush_last = fl_last;

  `LSC_ASSERT_IMPL(a_evict_only_full, clk, rst,
    cmd.out_load && cmd.sel == lsc_pkg::SEL_EVICT_COMMIT, &slot_valid,
    "eviction commit issued while a slot was free")
  `LSC_ASSERT_NEXT(a_flush_empties, clk, rst,
    cmd.out_load && cmd.sel == lsc_pkg::SEL_FLUSH_COMMIT && fl_last, slot_valid == '0,
    "final flush commit left an occupied slot")
  `LSC_ASSERT_NEXT(a_tick_only_on_grant, clk, rst, !stamp, $stable(use_tick),
    "use tick moved without a grant")
  `LSC_ASSERT_IMPL(a_load_needs_room, clk, rst, cmd.out_load, !out_valid || out_ready,
    "result loaded over an untaken result")

endmodule

@@ rtl/core/lru_sector_cache_tags_core.sv @@
// -----------------------------------------------------------------------------
// LRU sector cache tags: top level
// Fully associative write-back sector cache tag and LRU replacement control.
// -----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel (op, sector_index); results leave
// on the res channel (kind, slot, committed_sector, hit, fill, last). Each
// channel moves one transaction when valid and ready are both high.
// The block works on one request at a time. A request is taken in the idle
// state and decided in the following cycle; a lookup, a hitting get or a get
// that finds a free slot loads its result once the output register has room.
// A get that must evict runs a victim scan over the slot ticks, one slot per
// cycle, then emits the commit and then the grant, each once the output
// register has room. A flush emits one commit per occupied slot after the
// decide state, one per cycle while the receiver keeps taking them; an empty
// flush gives a single flush-done result. There is a single output register.
// The output register lets the next request be taken while a result still
// waits; when the receiver stalls, the controller holds in its emit state
// until the register drains. Synchronous reset empties every slot, clears
// the tick counter and drops any pending result; no clearing pass is needed.
// -----------------------------------------------------------------------------
module lru_sector_cache_tags_core #(
  parameter int NUM_SLOTS = lsc_pkg::NUM_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  lsc_req_if.sink   req,
  lsc_res_if.source res
);

  // Command and status bundles between the controller and the datapath.
  lsc_pkg::cmd_t cmd;
  lsc_pkg::sts_t sts;
  lsc_pkg::res_t out_data;
  logic          out_valid;

  lsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsc_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (req.op),
    .in_sec_idx (req.sector_index),
    .out_valid  (out_valid),
    .out_ready  (res.ready),
    .out_data   (out_data)
  );

  // The result register drives the outgoing channel directly.
  assign res.valid            = out_valid;
  assign res.kind             = out_data.kind;
  assign res.slot             = out_data.slot;
  assign res.committed_sector = out_data.committed_sector;
  assign res.hit              = out_data.hit;
  assign res.fill             = out_data.fill;
  assign res.last             = out_data.last;

endmodule
